FILE: hdl/sync_length_xor_frame_receiver_assert.svh
// Assertion macros used by the checker file.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SLXFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define SLXFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/slxfr_pkg.sv
package slxfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h06;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h85;

    // Result item kinds
    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Receiver phase
    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CMD   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } phase_t;

endpackage

FILE: hdl/slxfr_if.sv
interface slxfr_in_if;
    import slxfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slxfr_out_if;
    import slxfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic [KIND_W-1:0] item_kind;
    logic              checksum_good;
    logic              last_item;

    modport source (output valid, output byte_value, output item_kind,
                    output checksum_good, output last_item, input ready);
    modport sink   (input valid, input byte_value, input item_kind,
                    input checksum_good, input last_item, output ready);
endinterface

FILE: hdl/sync_length_xor_frame_receiver.sv
// Pipeline: a byte is registered on accept and its result item, if it has one, is loaded
// into the output register when that register is free or its item is being taken.
// Throughput: one byte per cycle unless frm stalls; phase and XOR update once per byte.
// Reset: rst_n (async, active low) empties both stages and returns the receiver to
// hunting for the first sync byte with the length count and checksum cleared.
module sync_length_xor_frame_receiver (
    input logic        clk,
    input logic        rst_n,
    slxfr_in_if.sink   rx,
    slxfr_out_if.source frm
);
    import slxfr_pkg::*;

    // Input stage
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    // Receiver state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    // Result stage
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_good_reg;
    logic              out_last_reg;

    // Result of the byte in the input stage
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic [KIND_W-1:0] res_kind;
    logic              res_good;
    logic              res_last;
    logic [BYTE_W-1:0] left_dec;

    logic out_free;
    logic advance;

    // Move the input-stage byte on when its result has room, or when it has none
    assign out_free = !out_valid_reg || frm.ready;
    assign advance  = s1_valid_reg && (out_free || !res_valid);
    assign rx.ready = !s1_valid_reg || advance;

    // Phase, count and checksum update
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        left_dec        = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;
        case (phase_reg)
            PH_HUNT1:
            begin
                if (s1_byte_reg == SYNC_SECOND)
                    phase_next = PH_LEN;
                else if (s1_byte_reg == SYNC_FIRST)
                    phase_next = PH_HUNT1;
                else
                    phase_next = PH_HUNT0;
            end
            PH_LEN:
            begin
                if (s1_byte_reg != '0)
                begin
                    xor_next        = s1_byte_reg;
                    bytes_left_next = s1_byte_reg - 1'b1;
                    phase_next      = PH_CMD;
                end
                else
                begin
                    phase_next = PH_HUNT0;
                end
            end
            PH_CMD:
            begin
                xor_next   = xor_reg ^ s1_byte_reg;
                phase_next = (bytes_left_reg == '0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                xor_next        = xor_reg ^ s1_byte_reg;
                bytes_left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_CSUM;
            end
            PH_CSUM:
            begin
                phase_next      = PH_HUNT0;
                bytes_left_next = '0;
                xor_next        = '0;
            end
            default:
            begin
                phase_next = (s1_byte_reg == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    // Result item for the current byte
    always_comb
    begin
        res_valid = 1'b0;
        res_byte  = s1_byte_reg;
        res_kind  = KIND_CMD;
        res_good  = 1'b0;
        res_last  = 1'b0;
        case (phase_reg)
            PH_CMD:
            begin
                res_valid = 1'b1;
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
            end
            PH_CSUM:
            begin
                res_valid = 1'b1;
                res_byte  = '0;
                res_kind  = KIND_END;
                res_good  = (s1_byte_reg == xor_reg);
                res_last  = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Input stage: take a beat whenever the stage is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            s1_byte_reg <= rx.rx_byte;
    end

    // State: commit when the byte moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT0;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
        end
    end

    // Result stage: load a new item, drop the one taken, or hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && res_valid)
        begin
            out_byte_reg <= res_byte;
            out_kind_reg <= res_kind;
            out_good_reg <= res_good;
            out_last_reg <= res_last;
        end
    end

    assign frm.valid         = out_valid_reg;
    assign frm.byte_value    = out_byte_reg;
    assign frm.item_kind     = out_kind_reg;
    assign frm.checksum_good = out_good_reg;
    assign frm.last_item     = out_last_reg;

endmodule

FILE: hdl/slxfr_checker.sv
`include "sync_length_xor_frame_receiver_assert.svh"

module slxfr_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    frm_valid,
    input logic                    frm_ready,
    input logic [slxfr_pkg::BYTE_W-1:0] frm_byte_value,
    input logic [slxfr_pkg::KIND_W-1:0] frm_item_kind,
    input logic                    frm_checksum_good,
    input logic                    frm_last_item
);
    import slxfr_pkg::*;

    // A stalled result item stays offered
    `SLXFR_ASSERT_NEXT(a_hold_valid, frm_valid && !frm_ready, frm_valid, "result dropped while stalled")

    // A frame end carries the end kind and no byte
    `SLXFR_ASSERT(a_end_form, !frm_valid || !frm_last_item || (frm_item_kind == KIND_END && frm_byte_value == '0), "malformed frame end")

    // Only a frame end closes a frame or reports a checksum
    `SLXFR_ASSERT(a_flags_on_end, !frm_valid || frm_item_kind == KIND_END || (!frm_last_item && !frm_checksum_good), "end flags on a byte item")

    // Every frame end is marked last
    `SLXFR_ASSERT(a_end_is_last, !frm_valid || frm_item_kind != KIND_END || frm_last_item, "frame end not marked last")

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .frm_valid         (frm.valid),
    .frm_ready         (frm.ready),
    .frm_byte_value    (frm.byte_value),
    .frm_item_kind     (frm.item_kind),
    .frm_checksum_good (frm.checksum_good),
    .frm_last_item     (frm.last_item)
);
